@@ rtl/core/crc8fre_pkg.sv @@
// Package for the CRC-8 framed register exchange.
// Holds codes, shared structs and the CRC-8 (poly 0x07) helpers.
// No dependencies.
package crc8fre_pkg;

   localparam int unsigned FRAME_LEN = 5;
   localparam logic [2:0]  LAST_BEAT = 3'(FRAME_LEN - 1);
   localparam logic [2:0]  REPLY_CRC_IDX = 3'd4;
   localparam logic [7:0]  CRC_POLY = 8'h07;
   localparam logic [3:0]  MAX_ATTEMPTS_RESET = 4'd3;

   typedef enum logic [1:0] {
      FUNC_REQUEST = 2'd0,
      FUNC_REPLY   = 2'd1,
      FUNC_TIMEOUT = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_CRC_ERR = 2'd1,
      STATUS_TIMEOUT = 2'd2
   } status_type;

   // Frame contents held for the emitter (and for resends).
   typedef struct packed {
      logic [7:0]  rd_addr;
      logic [7:0]  wr_addr;
      logic [15:0] wr_data;
   } held_type;

   // Work handed from control to the emitter at accept time.
   typedef struct packed {
      logic        frame;
      logic        done;
      status_type  status;
      logic [31:0] data;
   } batch_type;

   function automatic logic [7:0] rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7 - i];
      end
      return r;
   endfunction

   // One byte through the reflected-input CRC-8, MSB first.
   function automatic logic [7:0] crc_add(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ rev8(b);
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

endpackage

@@ rtl/core/crc8fre_ctrl.sv @@
// Exchange control: request latch, reply collection, CRC check, retry count.
// Depends on crc8fre_pkg.
module crc8fre_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [3:0]            csr_wdata,
   input  logic                  accept,
   input  logic [1:0]            func,
   input  logic [7:0]            rd_addr,
   input  logic [7:0]            wr_addr,
   input  logic [15:0]           wr_data,
   input  logic [7:0]            rx_byte,
   output crc8fre_pkg::held_type  held,
   output crc8fre_pkg::batch_type start
);

   logic [3:0]            max_attempts_ff, max_attempts_in;
   crc8fre_pkg::held_type held_ff, held_in;
   logic [3:0]            attempt_ff, attempt_in;
   logic [2:0]            count_ff, count_in;
   logic [7:0]            crc_ff, crc_in;
   logic [31:0]           word_ff, word_in;
   logic                  await_ff, await_in;

   always_comb begin
      max_attempts_in = csr_we ? csr_wdata : max_attempts_ff;
      held_in    = held_ff;
      attempt_in = attempt_ff;
      count_in   = count_ff;
      crc_in     = crc_ff;
      word_in    = word_ff;
      await_in   = await_ff;
      start      = '0;
      if (accept) begin
         case (func)
            crc8fre_pkg::FUNC_REQUEST: begin
               held_in.rd_addr = rd_addr;
               held_in.wr_addr = wr_addr;
               held_in.wr_data = wr_data;
               attempt_in  = 4'd1;
               count_in    = '0;
               crc_in      = '0;
               word_in     = '0;
               await_in    = 1'b1;
               start.frame = 1'b1;
            end
            crc8fre_pkg::FUNC_TIMEOUT: begin
               if (await_ff) begin
                  await_in     = 1'b0;
                  count_in     = '0;
                  start.done   = 1'b1;
                  start.status = crc8fre_pkg::STATUS_TIMEOUT;
               end
            end
            crc8fre_pkg::FUNC_REPLY: begin
               if (await_ff) begin
                  if (count_ff != crc8fre_pkg::REPLY_CRC_IDX) begin
                     crc_in = crc8fre_pkg::crc_add(crc_ff, rx_byte);
                     case (count_ff[1:0])
                        2'd0:    word_in[7:0]   = rx_byte;
                        2'd1:    word_in[15:8]  = rx_byte;
                        2'd2:    word_in[23:16] = rx_byte;
                        default: word_in[31:24] = rx_byte;
                     endcase
                     count_in = count_ff + 3'd1;
                  end else if (crc8fre_pkg::rev8(crc_ff) == rx_byte) begin
                     await_in     = 1'b0;
                     count_in     = '0;
                     start.done   = 1'b1;
                     start.status = crc8fre_pkg::STATUS_OK;
                     start.data   = word_ff;
                  end else if (attempt_ff >= max_attempts_ff) begin
                     await_in     = 1'b0;
                     count_in     = '0;
                     start.done   = 1'b1;
                     start.status = crc8fre_pkg::STATUS_CRC_ERR;
                  end else begin
                     // bad CRC, attempts left: resend the held frame
                     attempt_in  = attempt_ff + 4'd1;
                     count_in    = '0;
                     crc_in      = '0;
                     word_in     = '0;
                     start.frame = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_attempts_ff <= crc8fre_pkg::MAX_ATTEMPTS_RESET;
         held_ff         <= '0;
         attempt_ff      <= '0;
         count_ff        <= '0;
         crc_ff          <= '0;
         word_ff         <= '0;
         await_ff        <= 1'b0;
      end else begin
         max_attempts_ff <= max_attempts_in;
         held_ff         <= held_in;
         attempt_ff      <= attempt_in;
         count_ff        <= count_in;
         crc_ff          <= crc_in;
         word_ff         <= word_in;
         await_ff        <= await_in;
      end
   end

   assign held = held_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= crc8fre_pkg::REPLY_CRC_IDX)
      else $error("reply count out of range");

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      !await_ff |-> count_ff == 3'd0)
      else $error("reply count nonzero while idle");

   a_one_batch: assert property (@(posedge clock) disable iff (reset)
      !(start.frame && start.done))
      else $error("frame and completion started together");

endmodule

@@ rtl/core/crc8fre_emit.sv @@
// Result sequencer: plays out a 5-byte frame with running CRC, or one completion.
// Depends on crc8fre_pkg.
module crc8fre_emit (
   input  logic                   clock,
   input  logic                   reset,
   input  crc8fre_pkg::held_type  held,
   input  crc8fre_pkg::batch_type start,
   output logic                   free,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [47:0]            rsp_tdata,
   output logic                   rsp_tuser,
   output logic                   rsp_tlast
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [2:0]             beat_ff, beat_in;
   logic [7:0]             crc_ff, crc_in;
   crc8fre_pkg::status_type status_ff, status_in;
   logic [31:0]            data_ff, data_in;
   logic                   fire;
   logic                   final_beat;
   logic [7:0]             frame_byte;
   logic [7:0]             tx_byte;

   always_comb begin
      case (beat_ff)
         3'd0:    frame_byte = held.rd_addr;
         3'd1:    frame_byte = held.wr_addr;
         3'd2:    frame_byte = held.wr_data[7:0];
         3'd3:    frame_byte = held.wr_data[15:8];
         default: frame_byte = 8'h00;
      endcase
   end

   assign fire       = busy_ff && rsp_tready;
   assign final_beat = done_ff || (beat_ff == crc8fre_pkg::LAST_BEAT);
   assign free       = !busy_ff || (fire && final_beat);

   always_comb begin
      busy_in   = busy_ff;
      done_in   = done_ff;
      beat_in   = beat_ff;
      crc_in    = crc_ff;
      status_in = status_ff;
      data_in   = data_ff;
      if (fire) begin
         if (final_beat) begin
            busy_in = 1'b0;
         end else begin
            beat_in = beat_ff + 3'd1;
            crc_in  = crc8fre_pkg::crc_add(crc_ff, frame_byte);
         end
      end
      if (start.frame) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         beat_in = '0;
         crc_in  = '0;
      end else if (start.done) begin
         busy_in   = 1'b1;
         done_in   = 1'b1;
         status_in = start.status;
         data_in   = start.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         beat_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         beat_ff <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff    <= crc_in;
      status_ff <= status_in;
      data_ff   <= data_in;
   end

   assign tx_byte = done_ff ? 8'h00 :
                    (beat_ff == crc8fre_pkg::LAST_BEAT) ? crc8fre_pkg::rev8(crc_ff) :
                    frame_byte;

   assign rsp_tvalid = busy_ff;
   assign rsp_tuser  = done_ff;
   assign rsp_tlast  = !done_ff && (beat_ff == crc8fre_pkg::LAST_BEAT);
   assign rsp_tdata  = {6'b0,
                        done_ff ? data_ff : 32'h0,
                        done_ff ? status_ff : crc8fre_pkg::STATUS_OK,
                        tx_byte};

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      (start.frame || start.done) |-> free)
      else $error("batch started while a result was still pending");

   a_beat_range: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !done_ff) |-> beat_ff <= crc8fre_pkg::LAST_BEAT)
      else $error("frame beat out of range");

   a_last_then_idle: assert property (@(posedge clock) disable iff (reset)
      (fire && rsp_tlast && !start.frame && !start.done) |=> !busy_ff)
      else $error("sequencer still busy after frame end");

endmodule

@@ rtl/core/crc8_framed_register_exchange.sv @@
// Top level of the CRC-8 framed register exchange.
// Instantiates crc8fre_ctrl and crc8fre_emit; uses crc8fre_pkg.
//
//  channel  dir  handshake            payload
//  req_     in   req_tvalid/tready    tuser=func, tdata=addr/data/rx byte
//  rsp_     out  rsp_tvalid/tready    tuser=kind, tlast=last, tdata=byte/status/word
//  csr_     in   csr_we               csr_wdata=max_attempts
//
// A request (or a bad reply that triggers a resend) yields five frame items,
// one per cycle while rsp_ is not stalled; no new item is taken until the
// frame's last item leaves. A completion is a single result item. Items
// that give no result are accepted whenever the sequencer is free. A new
// item is taken in the cycle the last pending result leaves.
// Reset is synchronous: idle, nothing awaited, max_attempts back to 3.
// A stall on rsp_ holds the current result and blocks new items on req_.
module crc8_framed_register_exchange (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata,   // max_attempts
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // rd_addr[7:0], wr_addr[15:8],
                                    // wr_data[31:16], rx_byte[39:32]
   input  logic [1:0]  req_tuser,   // func
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // tx_byte[7:0], status[9:8],
                                    // read_data[41:10], zero fill[47:42]
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast    // last
);

   crc8fre_pkg::held_type  held;
   crc8fre_pkg::batch_type start;
   logic                   free;
   logic                   accept;

   // The sequencer frees up on the final beat's handshake, so a new input
   // item can be taken in the same cycle as the final beat leaves.
   assign req_tready = free;
   assign accept     = req_tvalid && free;

   crc8fre_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .accept     (accept),
      .func       (req_tuser),
      .rd_addr    (req_tdata[7:0]),
      .wr_addr    (req_tdata[15:8]),
      .wr_data    (req_tdata[31:16]),
      .rx_byte    (req_tdata[39:32]),
      .held       (held),
      .start      (start)
   );

   // Frame CRC is built beat by beat as the bytes go out.
   crc8fre_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .held       (held),
      .start      (start),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ bench/tb.sv @@
// Self-checking bench for crc8_framed_register_exchange.
// Depends on crc8fre_pkg and the block's top level. Nothing else is read.
// A scoreboard class predicts every result item from its own copy of the state.
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   // func code 3 has no enum member; the block must ignore it
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 200;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT = 400000;

   // One result item as the block should present it.
   typedef struct packed {
      logic        kind;
      logic [7:0]  tx_byte;
      logic        last;
      logic [1:0]  status;
      logic [31:0] read_data;
   } exch_result_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [3:0]  csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   // quiet: no idling on either side (last phase)
   bit quiet;
   // hold_off_go: ask the result side for one long stall
   bit hold_off_go;
   int live_items;
   int cycle_count;
   // attempt limit as the stimulus sees it (zero acts as one)
   int gen_limit;

   // ------------------------------------------------------------------
   // CRC-8, poly 0x07, init 0, fed with bit-reversed bytes
   // ------------------------------------------------------------------
   function automatic logic [7:0] flip_byte(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) r[i] = v[7 - i];
      return r;
   endfunction

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ flip_byte(b);
      repeat (8) begin
         if (c[7]) c = {c[6:0], 1'b0} ^ 8'h07;
         else c = {c[6:0], 1'b0};
      end
      return c;
   endfunction

   // ------------------------------------------------------------------
   // Scoreboard: tracks the exchange state and holds due result items.
   // ------------------------------------------------------------------
   class exchange_scoreboard;
      logic [3:0]      attempt_limit;
      logic [7:0]      rd_addr;
      logic [7:0]      wr_addr;
      logic [15:0]     wr_data;
      logic [3:0]      tries;
      logic [2:0]      nbytes;
      logic [7:0]      rx_crc;
      logic [31:0]     rx_word;
      bit              waiting;
      exch_result_type due_results[$];
      int              errors;

      function new();
         attempt_limit = crc8fre_pkg::MAX_ATTEMPTS_RESET;
         rd_addr = '0;
         wr_addr = '0;
         wr_data = '0;
         tries = '0;
         nbytes = '0;
         rx_crc = '0;
         rx_word = '0;
         waiting = 1'b0;
         errors = 0;
      endfunction

      function void set_limit(input logic [3:0] v);
         attempt_limit = v;
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      task report(input string msg);
         $display("%0t ns: MISMATCH %s", $realtime, msg);
         errors++;
      endtask

      // five frame bytes, CRC last; rearms reply collection
      function void queue_frame();
         logic [7:0]      fb[4];
         logic [7:0]      crc;
         exch_result_type r;
         fb = '{rd_addr, wr_addr, wr_data[7:0], wr_data[15:8]};
         crc = '0;
         r = '0;
         foreach (fb[i]) begin
            crc = crc8_update(crc, fb[i]);
            r.tx_byte = fb[i];
            due_results.push_back(r);
         end
         r.tx_byte = flip_byte(crc);
         r.last = 1'b1;
         due_results.push_back(r);
         nbytes = '0;
         rx_crc = '0;
         rx_word = '0;
         waiting = 1'b1;
      endfunction

      function void queue_done(input crc8fre_pkg::status_type st, input logic [31:0] word);
         exch_result_type r;
         r = '0;
         r.kind = 1'b1;
         r.status = st;
         r.read_data = word;
         due_results.push_back(r);
         waiting = 1'b0;
         nbytes = '0;
      endfunction

      // Called for every accepted input item.
      function void note_item(input logic [1:0] func, input logic [7:0] ra,
                              input logic [7:0] wa, input logic [15:0] wd,
                              input logic [7:0] rx);
         if (func == crc8fre_pkg::FUNC_REQUEST) begin
            rd_addr = ra;
            wr_addr = wa;
            wr_data = wd;
            tries = 4'd1;
            queue_frame();
         end else if (func == crc8fre_pkg::FUNC_TIMEOUT) begin
            if (waiting) queue_done(crc8fre_pkg::STATUS_TIMEOUT, '0);
         end else if (func == crc8fre_pkg::FUNC_REPLY && waiting) begin
            if (nbytes < 3'd4) begin
               rx_crc = crc8_update(rx_crc, rx);
               rx_word = rx_word | (32'(rx) << (8 * nbytes));
               nbytes = nbytes + 3'd1;
            end else if (flip_byte(rx_crc) == rx) begin
               queue_done(crc8fre_pkg::STATUS_OK, rx_word);
            end else if (tries >= attempt_limit) begin
               queue_done(crc8fre_pkg::STATUS_CRC_ERR, '0);
            end else begin
               tries = tries + 4'd1;
               queue_frame();
            end
         end
      endfunction

      // Called for every accepted result item.
      task check_result(input logic kind, input logic [7:0] tx, input logic last,
                        input logic [1:0] st, input logic [31:0] word,
                        input logic [5:0] fill);
         exch_result_type e;
         if (due_results.size() == 0) begin
            report($sformatf("result with nothing due: kind=%0d tx=%02h", kind, tx));
            return;
         end
         e = due_results.pop_front();
         if (kind !== e.kind) report($sformatf("kind %0d, want %0d", kind, e.kind));
         if (tx !== e.tx_byte) report($sformatf("tx_byte %02h, want %02h", tx, e.tx_byte));
         if (last !== e.last) report($sformatf("last %0d, want %0d", last, e.last));
         if (st !== e.status) report($sformatf("status %0d, want %0d", st, e.status));
         if (word !== e.read_data)
            report($sformatf("read_data %08h, want %08h", word, e.read_data));
         if (fill !== 6'd0) report($sformatf("tdata fill bits %02h not zero", fill));
      endtask
   endclass

   exchange_scoreboard sb;

   // ------------------------------------------------------------------
   // Block under test
   // ------------------------------------------------------------------
   crc8_framed_register_exchange i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // Monitor: both channels sampled at the rising edge. The result is checked
   // before the input is noted; an item's results never leave in its own cycle.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tuser, rsp_tdata[7:0], rsp_tlast, rsp_tdata[9:8],
                            rsp_tdata[41:10], rsp_tdata[47:42]);
         if (req_tvalid && req_tready)
            sb.note_item(req_tuser, req_tdata[7:0], req_tdata[15:8], req_tdata[31:16],
                         req_tdata[39:32]);
      end
   end

   // Result side: random ready/stall bursts, plus one long hold-off while
   // the sender keeps offering, so the block backs up into req_tready.
   initial begin
      bit held;
      held = 1'b0;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_go && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge clock);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus tasks
   // ------------------------------------------------------------------

   // Offer one item, optionally after an idle burst; returns once accepted.
   // live: item counts toward the random item budget.
   task automatic send_item(input logic [1:0] func, input logic [7:0] ra,
                            input logic [7:0] wa, input logic [15:0] wd,
                            input logic [7:0] rx, input bit live);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {rx, wd, wa, ra};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (live) live_items++;
   endtask

   task automatic request(input logic [7:0] ra, input logic [7:0] wa, input logic [15:0] wd);
      send_item(crc8fre_pkg::FUNC_REQUEST, ra, wa, wd, 8'($urandom), 1'b1);
   endtask

   task automatic reply_byte(input logic [7:0] b);
      send_item(crc8fre_pkg::FUNC_REPLY, 8'($urandom), 8'($urandom), 16'($urandom),
                b, 1'b1);
   endtask

   task automatic timeout_item();
      send_item(crc8fre_pkg::FUNC_TIMEOUT, 8'($urandom), 8'($urandom), 16'($urandom),
                8'($urandom), 1'b1);
   endtask

   // Items the block must drop: stray reply/timeout while idle, or func 3.
   task automatic stray_item(input logic [1:0] func);
      send_item(func, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom), 1'b0);
   endtask

   task automatic random_request();
      logic [7:0] wa;
      wa = ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom);
      request(8'($urandom), wa, 16'($urandom));
   endtask

   // Four data bytes then a CRC byte; a bad CRC gets a nonzero error pattern.
   // Func 3 items are sprinkled in now and then; they must not disturb state.
   task automatic send_reply(input logic [31:0] word, input bit good);
      logic [7:0] crc;
      logic [7:0] b;
      crc = '0;
      for (int i = 0; i < 4; i++) begin
         b = word[8*i +: 8];
         if ($urandom_range(0, 15) == 0) stray_item(FUNC_UNUSED);
         reply_byte(b);
         crc = crc8_update(crc, b);
      end
      b = flip_byte(crc);
      if (!good) b = b ^ 8'($urandom_range(1, 255));
      reply_byte(b);
   endtask

   // One complete exchange with random outcome: ok, CRC failure after the
   // attempt limit, or timeout part way through a reply. Sometimes a first
   // request is abandoned by a second one.
   task automatic run_exchange();
      int  tries;
      bit  all_bad;
      bit  good;
      if ($urandom_range(0, 5) == 0) begin
         random_request();
         repeat ($urandom_range(0, 4)) reply_byte(8'($urandom));
      end
      random_request();
      tries = 1;
      all_bad = ($urandom_range(0, 2) == 0);
      forever begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(0, 4)) reply_byte(8'($urandom));
            timeout_item();
            return;
         end
         good = !all_bad && $urandom_range(0, 1);
         send_reply($urandom, good);
         if (good || tries >= gen_limit) return;
         tries++;
      end
   endtask

   // Drop valid, wait for every due result, then let the block settle.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // max_attempts write, only while idle
   task automatic write_limit(input logic [3:0] v);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= v;
      sb.set_limit(v);
      gen_limit = (v == 4'd0) ? 1 : int'(v);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      logic [3:0] limits[5];
      int         rand_base;
      int         target;
      sb = new();
      quiet = 1'b0;
      hold_off_go = 1'b0;
      live_items = 0;
      gen_limit = int'(crc8fre_pkg::MAX_ATTEMPTS_RESET);
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = crc8fre_pkg::FUNC_REQUEST;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Directed part, reset attempt limit of 3.
      // all-zero frame and an all-zero good reply
      request(8'h00, 8'h00, 16'h0000);
      send_reply(32'h0000_0000, 1'b1);
      // stray reply byte, stray timeout and func 3, all while idle
      stray_item(crc8fre_pkg::FUNC_REPLY);
      stray_item(crc8fre_pkg::FUNC_TIMEOUT);
      stray_item(FUNC_UNUSED);
      // all-ones frame, timeout mid-reply
      request(8'hFF, 8'hFF, 16'hFFFF);
      reply_byte(8'($urandom));
      reply_byte(8'($urandom));
      timeout_item();
      // request while awaiting: abandoned, then a bad CRC forces a resend
      random_request();
      reply_byte(8'($urandom));
      reply_byte(8'($urandom));
      request(8'hA5, 8'h5A, 16'hC33C);
      send_reply($urandom, 1'b0);
      send_reply(32'hFFFF_FFFF, 1'b1);

      // Random part: several attempt limits, extremes included (zero acts
      // as one). The long result stall comes early in the first phase.
      limits = '{4'd1, 4'd15, 4'd0, 4'($urandom_range(2, 14)), 4'd3};
      rand_base = live_items;
      foreach (limits[p]) begin
         write_limit(limits[p]);
         if (p == 0) hold_off_go = 1'b1;
         if (p == 4) quiet = 1'b1;
         target = rand_base + RANDOM_ITEMS * (p + 1) / 5;
         while (live_items < target) begin
            if ($urandom_range(0, 5) == 0) begin
               case ($urandom_range(0, 2))
                  0: stray_item(crc8fre_pkg::FUNC_REPLY);
                  1: stray_item(crc8fre_pkg::FUNC_TIMEOUT);
                  default: stray_item(FUNC_UNUSED);
               endcase
            end else begin
               run_exchange();
            end
         end
      end

      wait_idle();
      if (sb.pending() == 0 && sb.errors == 0) $display("tb passed");
      else $display("tb failed");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/crc8fre_pkg.sv
rtl/core/crc8fre_ctrl.sv
rtl/core/crc8fre_emit.sv
rtl/core/crc8_framed_register_exchange.sv
bench/tb.sv
